>>> sv/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helpers for the pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned DivSteps = 32;

  localparam logic [31:0] B6_OFFSET  = 32'd4000;
  localparam logic [31:0] K_3038     = 32'd3038;
  localparam logic [31:0] K_N7357    = 32'hFFFF_E343;
  localparam logic [31:0] K_3791     = 32'd3791;
  localparam logic [31:0] K_50000    = 32'd50000;
  localparam logic [31:0] K_32768    = 32'd32768;

  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;
  localparam logic [2:0] REG_OSS     = 3'd5;

  typedef struct packed {
    logic [15:0] ut;
    logic [23:0] up;
    logic        flag;
    logic [31:0] x1;
    logic        neg;
    logic        big;
    logic [31:0] b5;
    logic [31:0] t;
    logic [31:0] b6;
    logic [31:0] m1;
    logic [31:0] m2;
    logic [31:0] m3;
    logic [31:0] m4;
    logic [31:0] b3;
    logic [31:0] x3;
    logic [31:0] b4;
    logic [31:0] b7;
    logic [31:0] p;
  } ctx_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] prod;
    prod = a * b;
    return prod[31:0];
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
    return $unsigned($signed(v) >>> n);
  endfunction

endpackage

>>> sv/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// Unsigned 32-bit restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module bpc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);

  logic [31:0] rem [0:bpc_pkg::DivSteps-1];
  logic [31:0] nq  [0:bpc_pkg::DivSteps-1];
  logic [31:0] dv  [0:bpc_pkg::DivSteps-1];
  logic [31:0] rem_next [0:bpc_pkg::DivSteps-1];
  logic [31:0] nq_next  [0:bpc_pkg::DivSteps-1];
  logic [31:0] dv_next  [0:bpc_pkg::DivSteps-1];

  always_comb begin
    logic [31:0] r_in;
    logic [31:0] n_in;
    logic [31:0] d_in;
    logic [32:0] rs;
    logic        ge;
    for (int k = 0; k < bpc_pkg::DivSteps; k++) begin
      if (k == 0) begin
        r_in = '0;
        n_in = num;
        d_in = den;
      end else begin
        r_in = rem[k-1];
        n_in = nq[k-1];
        d_in = dv[k-1];
      end
      rs = {r_in, n_in[31]};
      ge = rs >= {1'b0, d_in};
      rem_next[k] = ge ? 32'(rs - {1'b0, d_in}) : rs[31:0];
      nq_next[k]  = {n_in[30:0], ge};
      dv_next[k]  = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < bpc_pkg::DivSteps; k++) begin
        rem[k] <= rem_next[k];
        nq[k]  <= nq_next[k];
        dv[k]  <= dv_next[k];
      end
    end
  end

  assign quo = nq[bpc_pkg::DivSteps-1];

endmodule

>>> sv/barometric_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// Integer temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one raw temperature/pressure request per cycle and returns one
// result per request, in order. The pipeline is built from the two 32-stage
// radix-2 dividers (temperature correction and the pressure quotient) plus
// twelve arithmetic stages, the first of which captures the request at the
// accepting edge. The whole pipeline holds while a result waits at the output.
// Calibration must be written only while idle; the block does not enforce it.
module barometric_pressure_compensation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // raw_temperature[15:0], raw_pressure[39:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // temperature_tenths[15:0], pressure_pa[32:16], zero
  output logic [0:0]  m_tuser,   // out_of_range[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned D = bpc_pkg::DivSteps;

  logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md;
  logic [1:0]  oss;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1_ac2 <= '0;
      ac3_ac4 <= '0;
      ac5_ac6 <= '0;
      b1_b2   <= '0;
      mc_md   <= '0;
      oss     <= 2'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        bpc_pkg::REG_AC1_AC2: ac1_ac2 <= cfg_data;
        bpc_pkg::REG_AC3_AC4: ac3_ac4 <= cfg_data;
        bpc_pkg::REG_AC5_AC6: ac5_ac6 <= cfg_data;
        bpc_pkg::REG_B1_B2:   b1_b2   <= cfg_data;
        bpc_pkg::REG_MC_MD:   mc_md   <= cfg_data;
        bpc_pkg::REG_OSS:     oss     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bpc_pkg::sx16(ac1_ac2[31:16]);
  assign ac2 = bpc_pkg::sx16(ac1_ac2[15:0]);
  assign ac3 = bpc_pkg::sx16(ac3_ac4[31:16]);
  assign ac4 = {16'd0, ac3_ac4[15:0]};
  assign ac5 = {16'd0, ac5_ac6[31:16]};
  assign ac6 = {16'd0, ac5_ac6[15:0]};
  assign b1  = bpc_pkg::sx16(b1_b2[31:16]);
  assign b2  = bpc_pkg::sx16(b1_b2[15:0]);
  assign mc  = bpc_pkg::sx16(mc_md[31:16]);
  assign md  = bpc_pkg::sx16(mc_md[15:0]);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  bpc_pkg::ctx_t s1, s2, s3, s4, s5, s6, s7, s8, s9, s10, s11;
  bpc_pkg::ctx_t s1_next, s2_next, s3_next, s4_next, s5_next, s6_next;
  bpc_pkg::ctx_t s7_next, s8_next, s9_next, s10_next, s11_next;
  bpc_pkg::ctx_t dl1 [0:D-1];
  bpc_pkg::ctx_t dl2 [0:D-1];
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11;
  logic [D-1:0] vd1, vd2;

  logic [31:0] div1_num, div1_den, div1_q;
  logic [31:0] div2_num, div2_den, div2_q;

  logic [15:0] t_out;
  logic [16:0] p_out;
  logic        f_out;

  // stage 1: raw pressure alignment, first temperature product
  always_comb begin
    logic [23:0] raw;
    s1_next    = '0;
    raw        = s_tdata[39:16];
    s1_next.ut = s_tdata[15:0];
    case (oss)
      2'd0:    s1_next.up = {8'd0, raw[23:8]};
      2'd1:    s1_next.up = {7'd0, raw[23:7]};
      2'd2:    s1_next.up = {6'd0, raw[23:6]};
      2'd3:    s1_next.up = {5'd0, raw[23:5]};
      default: s1_next.up = '0;
    endcase
    s1_next.x1 = bpc_pkg::mul32(32'({16'd0, s_tdata[15:0]}) - ac6, ac5);
  end

  // stage 2: temperature divisor, signed to magnitude
  logic [31:0] s2_den_c, s2_num_c;
  always_comb begin
    logic [31:0] x1;
    s2_next      = s1;
    x1           = bpc_pkg::asr(s1.x1, 5'd15);
    s2_next.x1   = x1;
    s2_den_c     = x1 + md;
    s2_num_c     = {mc[20:0], 11'd0};
    s2_next.flag = s2_den_c == '0;
    s2_next.neg  = s2_den_c[31] ^ s2_num_c[31];
  end

  logic [31:0] s2_den, s2_num;
  assign div1_num = s2_num[31] ? 32'(0 - s2_num) : s2_num;
  assign div1_den = s2_den[31] ? 32'(0 - s2_den) : s2_den;

  bpc_div u_div_t (
    .clk (clk),
    .en  (en),
    .num (div1_num),
    .den (div1_den),
    .quo (div1_q)
  );

  // stage 3: B5, T, B6
  always_comb begin
    logic [31:0] x2;
    logic [31:0] b5;
    s3_next    = dl1[D-1];
    x2         = dl1[D-1].flag ? '0 : (dl1[D-1].neg ? 32'(0 - div1_q) : div1_q);
    b5         = dl1[D-1].x1 + x2;
    s3_next.b5 = b5;
    s3_next.t  = bpc_pkg::asr(b5 + 32'd8, 5'd4);
    s3_next.b6 = b5 - bpc_pkg::B6_OFFSET;
  end

  // stage 4: products of B6
  always_comb begin
    s4_next    = s3;
    s4_next.m1 = bpc_pkg::mul32(s3.b6, s3.b6);
    s4_next.m2 = bpc_pkg::mul32(ac2, s3.b6);
    s4_next.m3 = bpc_pkg::mul32(ac3, s3.b6);
  end

  // stage 5: products of the square term
  always_comb begin
    logic [31:0] sq;
    s5_next    = s4;
    sq         = bpc_pkg::asr(s4.m1, 5'd12);
    s5_next.m1 = bpc_pkg::mul32(b2, sq);
    s5_next.m4 = bpc_pkg::mul32(b1, sq);
  end

  // stage 6: B3 and the B4 term
  always_comb begin
    logic [31:0] x3a;
    logic [31:0] v;
    s6_next    = s5;
    x3a        = bpc_pkg::asr(s5.m1, 5'd11) + bpc_pkg::asr(s5.m2, 5'd11);
    v          = (({ac1[29:0], 2'b00} + x3a) << oss) + 32'd2;
    s6_next.b3 = bpc_pkg::asr(v + (v[31] ? 32'd3 : 32'd0), 5'd2);
    s6_next.x3 = bpc_pkg::asr(bpc_pkg::asr(s5.m3, 5'd13) + bpc_pkg::asr(s5.m4, 5'd16)
                              + 32'd2, 5'd2);
  end

  // stage 7: B4, B7
  always_comb begin
    logic [31:0] prod;
    s7_next    = s6;
    prod       = bpc_pkg::mul32(ac4, s6.x3 + bpc_pkg::K_32768);
    s7_next.b4 = {15'd0, prod[31:15]};
    s7_next.b7 = bpc_pkg::mul32({8'd0, s6.up} - s6.b3, bpc_pkg::K_50000 >> oss);
  end

  // stage 8: pressure dividend
  always_comb begin
    s8_next      = s7;
    s8_next.big  = s7.b7[31];
    s8_next.flag = s7.flag || (s7.b4 == '0);
  end

  assign div2_num = s8.big ? s8.b7 : {s8.b7[30:0], 1'b0};
  assign div2_den = s8.b4;

  bpc_div u_div_p (
    .clk (clk),
    .en  (en),
    .num (div2_num),
    .den (div2_den),
    .quo (div2_q)
  );

  // stage 9: pressure quotient
  always_comb begin
    s9_next = dl2[D-1];
    if (dl2[D-1].b4 == '0) begin
      s9_next.p = '0;
    end else if (dl2[D-1].big) begin
      s9_next.p = {div2_q[30:0], 1'b0};
    end else begin
      s9_next.p = div2_q;
    end
  end

  // stage 10: correction products
  always_comb begin
    logic [31:0] ps;
    s10_next    = s9;
    ps          = bpc_pkg::asr(s9.p, 5'd8);
    s10_next.m1 = bpc_pkg::mul32(ps, ps);
    s10_next.m2 = bpc_pkg::mul32(bpc_pkg::K_N7357, s9.p);
  end

  // stage 11
  always_comb begin
    s11_next    = s10;
    s11_next.m1 = bpc_pkg::mul32(s10.m1, bpc_pkg::K_3038);
  end

  // stage 12: final pressure, temperature and pressure saturation
  always_comb begin
    logic [31:0] p;
    logic        f;
    f = s11.flag;
    p = s11.p + bpc_pkg::asr(bpc_pkg::asr(s11.m1, 5'd16) + bpc_pkg::asr(s11.m2, 5'd16)
                             + bpc_pkg::K_3791, 5'd4);
    if ($signed(s11.t) > 32'sd32767) begin
      t_out = 16'h7FFF;
      f     = 1'b1;
    end else if ($signed(s11.t) < -32'sd32768) begin
      t_out = 16'h8000;
      f     = 1'b1;
    end else begin
      t_out = s11.t[15:0];
    end
    if (p[31]) begin
      p_out = '0;
      f     = 1'b1;
    end else if (p > 32'd131071) begin
      p_out = 17'h1FFFF;
      f     = 1'b1;
    end else begin
      p_out = p[16:0];
    end
    f_out = f;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s2_den <= s2_den_c;
      s2_num <= s2_num_c;
      dl1[0] <= s2;
      dl2[0] <= s8;
      for (int k = 1; k < D; k++) begin
        dl1[k] <= dl1[k-1];
        dl2[k] <= dl2[k-1];
      end
      s3  <= s3_next;
      s4  <= s4_next;
      s5  <= s5_next;
      s6  <= s6_next;
      s7  <= s7_next;
      s8  <= s8_next;
      s9  <= s9_next;
      s10 <= s10_next;
      s11 <= s11_next;
      m_tdata <= {7'd0, p_out, t_out};
      m_tuser <= f_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11} <= '0;
      vd1      <= '0;
      vd2      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1  <= s_tvalid;
      v2  <= v1;
      vd1 <= {vd1[D-2:0], v2};
      v3  <= vd1[D-1];
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      vd2 <= {vd2[D-2:0], v8};
      v9  <= vd2[D-1];
      v10 <= v9;
      v11 <= v10;
      m_tvalid <= v11;
    end
  end

  a_zero_div_flag: assert property (@(posedge clk) disable iff (rst)
    v9 && s9.b4 == '0 |-> s9.flag && s9.p == '0)
    else $error("zero pressure divisor without flag");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted request lost at pipeline entry");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !v1 && vd1 == '0 && vd2 == '0)
    else $error("pipeline not empty after reset");

endmodule
